### src/tapf_pkg.sv
// Package for the three-axis PD force filter.
// Holds widths, register indexes, reset values, the sequencer state type and
// the saturation helper. No dependencies.
package tapf_pkg;

  localparam int DATA_W    = 16;               // ports and registers
  localparam int REG_IDX_W = 3;                // eight configuration registers
  localparam int NUM_AXES  = 3;
  localparam int AXIS_W    = 2;
  localparam int ERR_W     = DATA_W + 1;       // target - pos
  localparam int DERR_W    = DATA_W + 2;       // e - prev_error
  localparam int OP_W      = DERR_W;           // shared multiplier operand width
  localparam int PROD_W    = 2 * OP_W;
  localparam int PD_W      = 35;               // kp*e + kd*de, Q8.24
  localparam int BLEND_W   = 54;               // blend accumulator, Q8.40
  localparam int FRAC_DROP = 32;               // Q8.40 to Q8.8
  localparam int F_W       = BLEND_W - FRAC_DROP;
  localparam int LO_SHIFT  = DATA_W;           // prev_force term is scaled by 2^16
  localparam int HI_SHIFT  = OP_W - 1;         // weight of the upper pd slice

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D_X = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P_Y = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P_Z = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D_Z = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTHING = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_Z_BIAS   = 3'd7;

  localparam logic [DATA_W-1:0] RST_GAIN_P_XY = 16'd6400;
  localparam logic [DATA_W-1:0] RST_GAIN_P_Z  = 16'd12800;
  localparam logic [DATA_W-1:0] RST_GAIN_D    = 16'd5120;
  localparam logic [DATA_W-1:0] RST_SMOOTHING = 16'd52429;
  localparam logic [DATA_W-1:0] RST_Z_BIAS    = 16'd51;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [OP_W-1:0] ONE_Q16 = OP_W'(1) << DATA_W;
  localparam logic signed [BLEND_W-1:0] ROUND_HALF = BLEND_W'(1) << (FRAC_DROP - 1);
  localparam logic signed [F_W:0] F_MAX =
    {{(F_W - DATA_W + 2){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [F_W:0] F_MIN =
    {{(F_W - DATA_W + 2){1'b1}}, {(DATA_W - 1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_F,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC_HI,
    ST_ROUND,
    ST_DONE
  } state_t;

  function automatic logic signed [DATA_W-1:0] sat_force(input logic signed [F_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > F_MAX) begin
      r = F_MAX[DATA_W-1:0];
    end else if (v < F_MIN) begin
      r = F_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/tapf_mul.sv
// Shared signed multiplier of the force filter, with a registered product.
// Depends on tapf_pkg for the operand width.
module tapf_mul
  import tapf_pkg::*;
(
  input  logic                     clk,
  input  logic signed [OP_W-1:0]   op_a,
  input  logic signed [OP_W-1:0]   op_b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

### src/three_axis_pd_force_filter.sv
// Three-axis PD force filter: top level with sequencer, state and configuration.
// Depends on tapf_pkg and tapf_mul.
//
// One word in gives one word out. Per axis the block forms e = target - pos and
// de = e - previous e, the PD term kp*e + kd*de, and blends it with the previous
// force as (1 - smoothing)*pd + smoothing*previous force, rounded half up to Q8.8,
// plus z_bias on the z axis, saturated to 16 bits. All products go through one
// registered 18x18 multiplier, five per axis, while the sequencer steps each axis
// through ST_ERR, ST_MUL_P, ST_MUL_D, ST_MUL_F, ST_MUL_LO, ST_MUL_HI, ST_ACC_HI and
// ST_ROUND. in_ready is high only while the sequencer is idle; a finished word waits
// in the output register while the next one is accepted. Configuration writes take
// effect at once; the user must keep them to idle periods, which is not enforced.
module three_axis_pd_force_filter
  import tapf_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [DATA_W-1:0]    pos_x,
  input  logic signed [DATA_W-1:0]    pos_y,
  input  logic signed [DATA_W-1:0]    pos_z,
  input  logic signed [DATA_W-1:0]    target_x,
  input  logic signed [DATA_W-1:0]    target_y,
  input  logic signed [DATA_W-1:0]    target_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_W-1:0]    force_x,
  output logic signed [DATA_W-1:0]    force_y,
  output logic signed [DATA_W-1:0]    force_z,
  input  logic                        wr_en,
  input  logic [REG_IDX_W-1:0]        wr_index,
  input  logic [DATA_W-1:0]           wr_data
);

  state_t state;
  state_t state_next;

  logic [DATA_W-1:0]        gain_p [NUM_AXES];
  logic [DATA_W-1:0]        gain_d [NUM_AXES];
  logic [DATA_W-1:0]        smoothing;
  logic signed [DATA_W-1:0] z_bias;

  logic signed [DATA_W-1:0] pos    [NUM_AXES];
  logic signed [DATA_W-1:0] target [NUM_AXES];
  logic signed [ERR_W-1:0]  prev_error [NUM_AXES];
  logic signed [DATA_W-1:0] prev_force [NUM_AXES];

  logic [AXIS_W-1:0]         axis;
  logic signed [ERR_W-1:0]   err;
  logic signed [DERR_W-1:0]  derr;
  logic signed [PD_W-1:0]    pd;
  logic signed [BLEND_W-1:0] blend;

  logic signed [ERR_W-1:0]   err_calc;
  logic signed [DERR_W-1:0]  derr_calc;
  logic [OP_W-1:0]           weight;
  logic signed [OP_W-1:0]    op_a;
  logic signed [OP_W-1:0]    op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [BLEND_W-1:0] prod_ext;
  logic signed [BLEND_W-1:0] rounded;
  logic signed [F_W:0]       force_biased;
  logic signed [DATA_W-1:0]  force_sat;
  logic                      in_take;
  logic                      out_free;

  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p[AXIS_X] <= RST_GAIN_P_XY;
      gain_p[AXIS_Y] <= RST_GAIN_P_XY;
      gain_p[AXIS_Z] <= RST_GAIN_P_Z;
      gain_d[AXIS_X] <= RST_GAIN_D;
      gain_d[AXIS_Y] <= RST_GAIN_D;
      gain_d[AXIS_Z] <= RST_GAIN_D;
      smoothing      <= RST_SMOOTHING;
      z_bias         <= RST_Z_BIAS;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAIN_P_X:  gain_p[AXIS_X] <= wr_data;
        REG_GAIN_D_X:  gain_d[AXIS_X] <= wr_data;
        REG_GAIN_P_Y:  gain_p[AXIS_Y] <= wr_data;
        REG_GAIN_D_Y:  gain_d[AXIS_Y] <= wr_data;
        REG_GAIN_P_Z:  gain_p[AXIS_Z] <= wr_data;
        REG_GAIN_D_Z:  gain_d[AXIS_Z] <= wr_data;
        REG_SMOOTHING: smoothing      <= wr_data;
        REG_Z_BIAS:    z_bias         <= wr_data;
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR:    state_next = ST_MUL_P;
      ST_MUL_P:  state_next = ST_MUL_D;
      ST_MUL_D:  state_next = ST_MUL_F;
      ST_MUL_F:  state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_ACC_HI;
      ST_ACC_HI: state_next = ST_ROUND;
      ST_ROUND: begin
        state_next = (axis == AXIS_Z) ? ST_DONE : ST_ERR;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Error terms of the current axis.
  assign err_calc  = ERR_W'(target[axis]) - ERR_W'(pos[axis]);
  assign derr_calc = DERR_W'(err) - DERR_W'(prev_error[axis]);
  assign weight    = ONE_Q16 - OP_W'(smoothing);

  // Operand selection for the shared multiplier. The pd term is split into a
  // low unsigned slice and a signed upper slice so each product stays 18x18.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_MUL_P: begin
        op_a = $signed(OP_W'(gain_p[axis]));
        op_b = OP_W'(err);
      end
      ST_MUL_D: begin
        op_a = $signed(OP_W'(gain_d[axis]));
        op_b = derr;
      end
      ST_MUL_F: begin
        op_a = $signed(OP_W'(smoothing));
        op_b = OP_W'(prev_force[axis]);
      end
      ST_MUL_LO: begin
        op_a = $signed(weight);
        op_b = $signed({1'b0, pd[HI_SHIFT-1:0]});
      end
      ST_MUL_HI: begin
        op_a = $signed(weight);
        op_b = pd[PD_W-1:HI_SHIFT];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  tapf_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign prod_ext = BLEND_W'(prod);

  // Round half up by adding half an LSB and keeping the upper bits.
  assign rounded      = blend + ROUND_HALF;
  assign force_biased = (F_W + 1)'($signed(rounded[BLEND_W-1:FRAC_DROP])) +
                        ((axis == AXIS_Z) ? (F_W + 1)'(z_bias) : '0);
  assign force_sat    = sat_force(force_biased);

  // Datapath. Each state reads the product of the previous state's operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= AXIS_X;
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_error[i] <= '0;
        prev_force[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          axis <= AXIS_X;
          if (in_take) begin
            pos[AXIS_X]    <= pos_x;
            pos[AXIS_Y]    <= pos_y;
            pos[AXIS_Z]    <= pos_z;
            target[AXIS_X] <= target_x;
            target[AXIS_Y] <= target_y;
            target[AXIS_Z] <= target_z;
          end
        end
        ST_ERR: begin
          err <= err_calc;
        end
        ST_MUL_P: begin
          derr <= derr_calc;
        end
        ST_MUL_D:  pd    <= prod[PD_W-1:0];
        ST_MUL_F:  pd    <= pd + prod[PD_W-1:0];
        ST_MUL_LO: blend <= prod_ext <<< LO_SHIFT;
        ST_MUL_HI: blend <= blend + prod_ext;
        ST_ACC_HI: blend <= blend + (prod_ext <<< HI_SHIFT);
        ST_ROUND: begin
          prev_error[axis] <= err;
          prev_force[axis] <= force_sat;
          if (axis != AXIS_Z) begin
            axis <= axis + AXIS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: the finished word waits here while the next one starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      force_x <= prev_force[AXIS_X];
      force_y <= prev_force[AXIS_Y];
      force_z <= prev_force[AXIS_Z];
    end
  end

  // A new word always starts on the x axis.
  a_start_x : assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_ERR && axis == AXIS_X)
    else $error("word did not start on the x axis");

  // The axis counter never leaves the three axes.
  a_axis_range : assert property (@(posedge clk) disable iff (rst)
    axis == AXIS_X || axis == AXIS_Y || axis == AXIS_Z)
    else $error("axis counter out of range");

  // Finishing the z axis ends the word.
  a_z_done : assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND && axis == AXIS_Z |=> state == ST_DONE)
    else $error("z axis did not close the word");

  // Handing off a result always presents it and frees the sequencer.
  a_handoff : assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> out_valid && state == ST_IDLE)
    else $error("result handoff lost");

endmodule
